// ----- rtl/rvis_pkg.sv -----
// Shared types, constants and helper functions for the RV32I step core.
// No dependencies; every other file imports this package.
package rvis_pkg;

  localparam int MEM_BYTES = 65536;
  localparam logic [31:0] MEM_BASE = 32'h8000_0000;
  localparam int ROWS = MEM_BYTES / 4;
  localparam int ROW_AW = $clog2(ROWS);
  localparam int MEM_AW = ROW_AW + 2;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_REG    = 7'h33;
  localparam logic [6:0] OPC_FENCE  = 7'h0f;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  localparam logic [2:0] F3_SB = 3'd0;
  localparam logic [2:0] F3_SH = 3'd1;
  localparam logic [2:0] F3_SW = 3'd2;

  localparam logic [31:0] WORD_ZERO = 32'h0000_0000;
  localparam logic [31:0] WORD_ONES = 32'hffff_ffff;

  localparam logic OPN_BYTE = 1'b0;
  localparam logic OPN_STEP = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_END      = 3'd1,
    ST_ECALL    = 3'd2,
    ST_MISALIGN = 3'd3,
    ST_FUNCT    = 3'd4,
    ST_OPCODE   = 3'd5,
    ST_RANGE    = 3'd6
  } status_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] byte_address;
    logic [7:0]  byte_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] executed_pc;
    logic [31:0] instruction_word;
    logic [31:0] next_pc;
    logic        halted;
    status_t     status;
  } out_item_t;

  typedef struct packed {
    logic        is_step;
    logic [15:0] byte_address;
    logic [7:0]  byte_data;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } fq_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } bk_ctl_t;

  // Row of byte lane 'lane' for an access starting at byte offset 'off'.
  function automatic logic [ROW_AW-1:0] lane_row(input logic [MEM_AW-1:0] off,
                                                 input logic [1:0] lane);
    lane_row = off[MEM_AW-1:2] + ROW_AW'(lane < off[1:0]);
  endfunction

  // Put the lane bytes back in access order.
  function automatic logic [31:0] lane_gather(input logic [31:0] q, input logic [1:0] lo);
    logic [63:0] dbl;
    dbl = {q, q};
    lane_gather = dbl[{lo, 3'b000} +: 32];
  endfunction

  // Spread access-order bytes onto the lanes.
  function automatic logic [31:0] lane_scatter(input logic [31:0] d, input logic [1:0] lo);
    logic [63:0] dbl;
    dbl = {d, d};
    lane_scatter = dbl[6'd32 - {1'b0, lo, 3'b000} +: 32];
  endfunction

  function automatic logic [3:0] lane_enable(input logic [3:0] m, input logic [1:0] lo);
    logic [7:0] dbl;
    dbl = {m, m};
    lane_enable = dbl[3'd4 - {1'b0, lo} +: 4];
  endfunction

endpackage

// ----- rtl/rvis_front.sv -----
// Front end: accepts input words, tags them as byte write or step, and queues them.
// Depends on rvis_pkg.
module rvis_front import rvis_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  bk_ctl_t  bk,
  output fq_t      fq
);

  q_item_t    ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ready = !bk.busy && (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign fq.valid = (cnt_r != 2'd0);
  assign fq.item  = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = bk.pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(bk.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // classify on entry
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= '{is_step:      (in_item.operation == OPN_STEP),
                       byte_address: in_item.byte_address,
                       byte_data:    in_item.byte_data};
    end
  end

endmodule

// ----- rtl/rvis_back.sv -----
// Back end: byte memory in four lanes, register file, sequencer and result register.
// Depends on rvis_pkg.
module rvis_back import rvis_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  fq_t       fq,
  output bk_ctl_t   bk,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_FET  = 5'b00100,
    S_RD   = 5'b01000,
    S_LD   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [ROW_AW-1:0] clr_r, clr_nxt;
  logic [31:0]       pc_r, pc_nxt;
  logic              stopped_r, stopped_nxt;
  logic              pend_r, pend_nxt;
  out_item_t         res_r, res_nxt;
  logic              ov_r, ov_nxt;
  out_item_t         oi_r, oi_nxt;
  logic [31:0]       ins_r, ins_nxt;
  logic [1:0]        lo_r, lo_nxt;
  logic [4:0]        ldrd_r, ldrd_nxt;
  logic [2:0]        ldf3_r, ldf3_nxt;

  // register file: two copies for two read ports
  logic [31:0] rf_a [32];
  logic [31:0] rf_b [32];
  logic [31:0] rf_vld_r;
  logic [31:0] rfa_r, rfb_r;
  logic        rfa_v_r, rfb_v_r;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;

  // memory lanes
  logic [7:0]        bank_rd_r [4];
  logic [ROW_AW-1:0] mem_raddr [4];
  logic [ROW_AW-1:0] mem_waddr [4];
  logic              mem_we    [4];
  logic [7:0]        mem_wd    [4];
  logic [31:0]       bank_word;

  logic [31:0]       fetch_off;
  logic              fetch_ok;
  logic [31:0]       fetch_word;
  logic [MEM_AW-1:0] rd_off;
  logic              can_push;

  // execute outputs
  logic [31:0] ex_a, ex_b;
  status_t     ex_st;
  logic [31:0] ex_npc, ex_wd, ex_off;
  logic        ex_we, ex_ld, ex_sto, ex_halt;
  logic [3:0]  ex_mask;
  logic [31:0] st_lane_d;
  logic [3:0]  st_lane_en;
  logic [31:0] ld_word, ld_val;
  logic [31:0] ba32;

  assign bank_word  = {bank_rd_r[3], bank_rd_r[2], bank_rd_r[1], bank_rd_r[0]};
  assign fetch_off  = pc_r - MEM_BASE;
  assign fetch_ok   = ({1'b0, fetch_off} + 33'd4) <= 33'(MEM_BYTES);
  assign fetch_word = lane_gather(bank_word, lo_r);
  assign rd_off     = (state_r == S_RD) ? ex_off[MEM_AW-1:0] : fetch_off[MEM_AW-1:0];
  assign can_push   = !ov_r || out_ready;
  assign ex_a       = rfa_v_r ? rfa_r : 32'h0;
  assign ex_b       = rfb_v_r ? rfb_r : 32'h0;
  assign st_lane_d  = lane_scatter(ex_b, ex_off[1:0]);
  assign st_lane_en = lane_enable(ex_mask, ex_off[1:0]);
  assign ld_word    = lane_gather(bank_word, lo_r);
  assign ba32       = 32'(fq.item.byte_address);
  assign out_valid  = ov_r;
  assign out_item   = oi_r;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    logic [7:0] bank [ROWS];
    assign mem_raddr[g] = lane_row(rd_off, 2'(g));
    always_ff @(posedge clk) begin
      if (mem_we[g]) bank[mem_waddr[g]] <= mem_wd[g];
      bank_rd_r[g] <= bank[mem_raddr[g]];
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we && rf_wa != 5'd0) begin
      rf_a[rf_wa] <= rf_wd;
      rf_b[rf_wa] <= rf_wd;
    end
    rfa_r <= rf_a[fetch_word[19:15]];
    rfb_r <= rf_b[fetch_word[24:20]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= 32'h0;
      rfa_v_r  <= 1'b0;
      rfb_v_r  <= 1'b0;
    end else begin
      if (rf_we && rf_wa != 5'd0) rf_vld_r[rf_wa] <= 1'b1;
      rfa_v_r <= rf_vld_r[fetch_word[19:15]];
      rfb_v_r <= rf_vld_r[fetch_word[24:20]];
    end
  end

  // decode and execute of ins_r against the register operands
  always_comb begin
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] immi, imms, immb, immj, seq, tgt, opb, alu;
    logic [4:0]  sh;
    logic        take, is_reg, alt, legal, br_bad, sz_bad;
    logic [2:0]  sz;
    logic [32:0] end_off;
    opc  = ins_r[6:0];
    f3   = ins_r[14:12];
    f7   = ins_r[31:25];
    immi = {{20{ins_r[31]}}, ins_r[31:20]};
    imms = {{20{ins_r[31]}}, ins_r[31:25], ins_r[11:7]};
    immb = {{19{ins_r[31]}}, ins_r[31], ins_r[7], ins_r[30:25], ins_r[11:8], 1'b0};
    immj = {{11{ins_r[31]}}, ins_r[31], ins_r[19:12], ins_r[20], ins_r[30:21], 1'b0};
    seq  = pc_r + 32'd4;
    ex_st = ST_OK;
    ex_npc = seq;
    ex_we = 1'b0;
    ex_wd = 32'h0;
    ex_ld = 1'b0;
    ex_sto = 1'b0;
    ex_off = 32'h0;
    ex_mask = 4'b1111;
    tgt = 32'h0;
    is_reg = (opc == OPC_REG);
    alt = (f7 == F7_ALT);
    opb = is_reg ? ex_b : immi;
    sh = is_reg ? ex_b[4:0] : ins_r[24:20];
    sz = 3'd4;
    sz_bad = 1'b0;
    end_off = 33'h0;

    case (f3)
      F3_ADD:  alu = (is_reg && alt) ? ex_a - ex_b : ex_a + opb;
      F3_SLL:  alu = ex_a << sh;
      F3_SLT:  alu = {31'h0, $signed(ex_a) < $signed(opb)};
      F3_SLTU: alu = {31'h0, ex_a < opb};
      F3_XOR:  alu = ex_a ^ opb;
      F3_SR:   alu = alt ? 32'($signed(ex_a) >>> sh) : ex_a >> sh;
      F3_OR:   alu = ex_a | opb;
      default: alu = ex_a & opb;
    endcase

    if (is_reg) begin
      legal = (f7 == F7_BASE) || (alt && (f3 == F3_ADD || f3 == F3_SR));
    end else if (f3 == F3_SLL) begin
      legal = (f7 == F7_BASE);
    end else if (f3 == F3_SR) begin
      legal = (f7 == F7_BASE) || alt;
    end else begin
      legal = 1'b1;
    end

    br_bad = 1'b0;
    case (f3)
      F3_BEQ:  take = (ex_a == ex_b);
      F3_BNE:  take = (ex_a != ex_b);
      F3_BLT:  take = $signed(ex_a) < $signed(ex_b);
      F3_BGE:  take = !($signed(ex_a) < $signed(ex_b));
      F3_BLTU: take = ex_a < ex_b;
      F3_BGEU: take = ex_a >= ex_b;
      default: begin
        take = 1'b0;
        br_bad = 1'b1;
      end
    endcase

    if (ins_r == WORD_ZERO || ins_r == WORD_ONES) begin
      ex_st = ST_END;
    end else begin
      unique case (opc)
        OPC_LUI: begin
          ex_we = 1'b1;
          ex_wd = {ins_r[31:12], 12'h000};
        end
        OPC_AUIPC: begin
          ex_we = 1'b1;
          ex_wd = pc_r + {ins_r[31:12], 12'h000};
        end
        OPC_JAL: begin
          tgt = pc_r + immj;
          if (tgt[1:0] != 2'b00) begin
            ex_st = ST_MISALIGN;
          end else begin
            ex_we = 1'b1;
            ex_wd = seq;
            ex_npc = tgt;
          end
        end
        OPC_JALR: begin
          tgt = (ex_a + immi) & ~32'h1;
          if (f3 != F3_ADD) begin
            ex_st = ST_FUNCT;
          end else if (tgt[1]) begin
            ex_st = ST_MISALIGN;
          end else begin
            ex_we = 1'b1;
            ex_wd = seq;
            ex_npc = tgt;
          end
        end
        OPC_BRANCH: begin
          tgt = pc_r + immb;
          if (br_bad) begin
            ex_st = ST_FUNCT;
          end else if (take) begin
            if (tgt[1:0] != 2'b00) ex_st = ST_MISALIGN;
            else ex_npc = tgt;
          end
        end
        OPC_LOAD: begin
          ex_off = ex_a + immi - MEM_BASE;
          case (f3)
            F3_LB, F3_LBU: begin
              sz = 3'd1;
              ex_mask = 4'b0001;
            end
            F3_LH, F3_LHU: begin
              sz = 3'd2;
              ex_mask = 4'b0011;
            end
            F3_LW: sz = 3'd4;
            default: sz_bad = 1'b1;
          endcase
          end_off = {1'b0, ex_off} + 33'(sz);
          if (sz_bad) ex_st = ST_FUNCT;
          else if (end_off > 33'(MEM_BYTES)) ex_st = ST_RANGE;
          else ex_ld = 1'b1;
        end
        OPC_STORE: begin
          ex_off = ex_a + imms - MEM_BASE;
          case (f3)
            F3_SB: begin
              sz = 3'd1;
              ex_mask = 4'b0001;
            end
            F3_SH: begin
              sz = 3'd2;
              ex_mask = 4'b0011;
            end
            F3_SW: sz = 3'd4;
            default: sz_bad = 1'b1;
          endcase
          end_off = {1'b0, ex_off} + 33'(sz);
          if (sz_bad) ex_st = ST_FUNCT;
          else if (end_off > 33'(MEM_BYTES)) ex_st = ST_RANGE;
          else ex_sto = 1'b1;
        end
        OPC_IMM, OPC_REG: begin
          if (legal) begin
            ex_we = 1'b1;
            ex_wd = alu;
          end else begin
            ex_st = ST_FUNCT;
          end
        end
        OPC_FENCE: ;
        OPC_SYSTEM: begin
          if (ins_r[31:20] == 12'h000) ex_st = ST_ECALL;
        end
        default: ex_st = ST_OPCODE;
      endcase
    end

    // a halting step writes nothing and keeps the pc
    ex_halt = (ex_st == ST_END) || (ex_st == ST_ECALL) || (ex_st == ST_MISALIGN) ||
              (ex_st == ST_RANGE);
    if (ex_halt) begin
      ex_npc = pc_r;
      ex_we = 1'b0;
      ex_ld = 1'b0;
      ex_sto = 1'b0;
    end
  end

  always_comb begin
    case (ldf3_r)
      F3_LB:   ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
      F3_LH:   ld_val = {{16{ld_word[15]}}, ld_word[15:0]};
      F3_LBU:  ld_val = {24'h0, ld_word[7:0]};
      F3_LHU:  ld_val = {16'h0, ld_word[15:0]};
      default: ld_val = ld_word;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    pc_nxt      = pc_r;
    stopped_nxt = stopped_r;
    pend_nxt    = pend_r;
    res_nxt     = res_r;
    ov_nxt      = ov_r;
    oi_nxt      = oi_r;
    ins_nxt     = ins_r;
    lo_nxt      = lo_r;
    ldrd_nxt    = ldrd_r;
    ldf3_nxt    = ldf3_r;
    bk.pop      = 1'b0;
    bk.busy     = (state_r == S_CLR);
    rf_we       = 1'b0;
    rf_wa       = ins_r[11:7];
    rf_wd       = ex_wd;
    for (int l = 0; l < 4; l++) begin
      mem_we[l]    = 1'b0;
      mem_waddr[l] = lane_row(ex_off[MEM_AW-1:0], 2'(l));
      mem_wd[l]    = st_lane_d[8*l +: 8];
    end

    if (ov_r && out_ready) ov_nxt = 1'b0;

    unique case (state_r)
      S_CLR: begin
        for (int l = 0; l < 4; l++) begin
          mem_we[l]    = 1'b1;
          mem_waddr[l] = clr_r;
          mem_wd[l]    = 8'h00;
        end
        clr_nxt = clr_r + ROW_AW'(1);
        if (clr_r == ROW_AW'(ROWS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (pend_r && can_push) begin
          ov_nxt   = 1'b1;
          oi_nxt   = res_r;
          pend_nxt = 1'b0;
        end
        if (fq.valid && (!pend_r || can_push)) begin
          bk.pop = 1'b1;
          res_nxt = '{executed_pc: pc_r, instruction_word: WORD_ZERO, next_pc: pc_r,
                      halted: stopped_r, status: ST_OK};
          if (!fq.item.is_step) begin
            if (ba32 < 32'(MEM_BYTES)) begin
              for (int l = 0; l < 4; l++) begin
                mem_we[l]    = (ba32[1:0] == 2'(l));
                mem_waddr[l] = ba32[MEM_AW-1:2];
                mem_wd[l]    = fq.item.byte_data;
              end
            end
            pend_nxt = 1'b1;
          end else if (stopped_r) begin
            pend_nxt = 1'b1;
          end else if (!fetch_ok) begin
            stopped_nxt = 1'b1;
            res_nxt.halted = 1'b1;
            res_nxt.status = ST_RANGE;
            pend_nxt = 1'b1;
          end else begin
            lo_nxt = fetch_off[1:0];
            state_nxt = S_FET;
          end
        end
      end
      S_FET: begin
        ins_nxt = fetch_word;
        state_nxt = S_RD;
      end
      S_RD: begin
        if (ex_ld) begin
          lo_nxt = ex_off[1:0];
          ldrd_nxt = ins_r[11:7];
          ldf3_nxt = ins_r[14:12];
          state_nxt = S_LD;
        end else begin
          if (ex_sto) begin
            for (int l = 0; l < 4; l++) mem_we[l] = st_lane_en[l];
          end
          rf_we = ex_we;
          pc_nxt = ex_npc;
          stopped_nxt = stopped_r || ex_halt;
          res_nxt = '{executed_pc: pc_r, instruction_word: ins_r, next_pc: ex_npc,
                      halted: stopped_r || ex_halt, status: ex_st};
          pend_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LD: begin
        rf_we = 1'b1;
        rf_wa = ldrd_r;
        rf_wd = ld_val;
        pc_nxt = pc_r + 32'd4;
        res_nxt = '{executed_pc: pc_r, instruction_word: ins_r, next_pc: pc_r + 32'd4,
                    halted: 1'b0, status: ST_OK};
        pend_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_r     <= '0;
      pc_r      <= MEM_BASE;
      stopped_r <= 1'b0;
      pend_r    <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      pc_r      <= pc_nxt;
      stopped_r <= stopped_nxt;
      pend_r    <= pend_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    oi_r   <= oi_nxt;
    ins_r  <= ins_nxt;
    lo_r   <= lo_nxt;
    ldrd_r <= ldrd_nxt;
    ldf3_r <= ldf3_nxt;
  end

endmodule

// ----- rtl/rv32i_instruction_step_core.sv -----
// Top level of the RV32I step core: front queue plus execution back end.
// Depends on rvis_pkg, rvis_front and rvis_back.
//
//   channel   direction  handshake                  word
//   in_       input      in_valid / in_ready        in_item_t  (byte write or step)
//   out_      output     out_valid / out_ready      out_item_t (one per input word)
//
// Steps: a byte write is done in the back end's idle state; an ALU, jump, branch or
// store step passes through fetch read of the memory lanes, register file read and
// execute; a load step adds the data read of the memory lanes.
// Reset: after rst_n the back end clears the byte memory one 4-byte row a cycle,
// with in_ready held low.
// Stalls: a two-word queue holds input words while the back end works; a
// pending result waits for the output register, and the queue is not popped meanwhile.
module rv32i_instruction_step_core import rvis_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  fq_t     fq;
  bk_ctl_t bk;

  // accept, classify and queue
  rvis_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .bk       (bk),
    .fq       (fq)
  );

  // execute and hold the result word
  rvis_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fq        (fq),
    .bk        (bk),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ----- rtl/rvis_checker.sv -----
// Port-level checks for the RV32I step core, bound to the top level.
// Depends on rvis_pkg.
module rvis_checker import rvis_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_item))
    else $error("input word changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result word changed while stalled");

  a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_END || out_item.status == ST_ECALL ||
                  out_item.status == ST_MISALIGN || out_item.status == ST_RANGE)
    |-> out_item.halted && out_item.next_pc == out_item.executed_pc)
    else $error("halting step did not halt in place");

  a_skip_pc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_FUNCT || out_item.status == ST_OPCODE)
    |-> !out_item.halted && out_item.next_pc == out_item.executed_pc + 32'd4)
    else $error("skipped instruction did not advance by four");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_item.halted |=> !out_valid || out_item.halted)
    else $error("core left the halted state");

endmodule

bind rv32i_instruction_step_core rvis_checker u_rvis_checker (.*);
